[hw/rtl/ple_pkg.sv]
// Shared types and codes for the positional list engine.
package ple_pkg;

	localparam logic [2:0] OP_INS_FRONT = 3'd0;
	localparam logic [2:0] OP_INS_END   = 3'd1;
	localparam logic [2:0] OP_INS_AT    = 3'd2;
	localparam logic [2:0] OP_DEL_FRONT = 3'd3;
	localparam logic [2:0] OP_DEL_END   = 3'd4;
	localparam logic [2:0] OP_DEL_AT    = 3'd5;
	localparam logic [2:0] OP_TRAVERSE  = 3'd6;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_OVERFLOW  = 3'd1;
	localparam logic [2:0] ST_UNDERFLOW = 3'd2;
	localparam logic [2:0] ST_BADPOS    = 3'd3;
	localparam logic [2:0] ST_BEYOND    = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [7:0]  position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data;
		logic               last;
	} rsp_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_LEFT,
		CM_RIGHT,
		CM_LOAD,
		CM_FRONT
	} cell_mode_t;

endpackage

[hw/rtl/positional_list_engine_core.sv]
// Top level of the positional list engine: control, length and the cell chain.
//
// Usage:
//   A request (req: op, position, value) is taken at a rising edge where
//   start is high and busy is low. Every op except traverse gives one
//   result, shown on rsp with rsp_valid high for one cycle, the cycle after
//   the request is taken; busy stays low, so a new request may follow in
//   every cycle. Inserts and deletes change only the cells from the
//   position on, all at once. Traverse of a list of length N > 0 raises
//   busy and emits N results, one per cycle; the front cell is read out
//   while the occupied cells rotate by one place, so the list is back in
//   order after the last one. An empty traverse gives one empty status
//   the next cycle. Op 7 gives no result.
//   The rsp.last bit marks the final result of each request.
//   Reset clears the length, the traverse state and rsp_valid; cell
//   contents are not reset. The receiver cannot stall: each result is
//   valid for exactly one cycle.
module positional_list_engine_core #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  ple_pkg::req_t req,
	output logic          busy,
	output logic          rsp_valid,
	output ple_pkg::rsp_t rsp
);
	import ple_pkg::*;

	localparam int LW   = $clog2(CAPACITY + 1);
	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMPW = (LW > 7) ? LW + 1 : 8;
	localparam logic [CMPW-1:0] CAP_C = CMPW'(CAPACITY);

	typedef enum logic {
		S_IDLE,
		S_TRAV
	} state_t;

	state_t     state_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] cnt_q;
	logic       rsp_valid_q;
	rsp_t       rsp_q;

	logic signed [31:0] cell_val [CAPACITY];
	cell_mode_t         cell_mode [CAPACITY];

	logic            accept;
	logic            neg;
	logic [CMPW-1:0] len_c;
	logic [CMPW-1:0] pos_c;
	logic            do_ins;
	logic            do_del;
	logic [2:0]      status_c;
	logic            emit_c;
	logic [IW-1:0]   del_idx;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_TRAV);
	assign neg    = req.position[7];
	assign len_c  = CMPW'(len_q);

	always_comb begin
		pos_c    = '0;
		do_ins   = 1'b0;
		do_del   = 1'b0;
		status_c = ST_OK;
		emit_c   = 1'b1;
		case (req.op)
			OP_INS_FRONT, OP_INS_END, OP_INS_AT: begin
				if (req.op == OP_INS_FRONT)
					pos_c = '0;
				else if (req.op == OP_INS_END)
					pos_c = len_c;
				else
					pos_c = CMPW'(req.position[6:0]);
				if (req.op == OP_INS_AT && neg)
					status_c = ST_BADPOS;
				else if (len_c >= CAP_C)
					status_c = ST_OVERFLOW;
				else if (pos_c > len_c)
					status_c = ST_BEYOND;
				else
					do_ins = 1'b1;
			end
			OP_DEL_FRONT, OP_DEL_END: begin
				pos_c = (req.op == OP_DEL_FRONT) ? '0 : len_c - CMPW'(1);
				if (len_q == '0)
					status_c = ST_UNDERFLOW;
				else
					do_del = 1'b1;
			end
			OP_DEL_AT: begin
				pos_c = CMPW'(req.position[6:0]);
				if (neg)
					status_c = ST_BADPOS;
				else if (pos_c == '0 && len_q == '0)
					status_c = ST_UNDERFLOW;
				else if (pos_c >= len_c)
					status_c = ST_BEYOND;
				else
					do_del = 1'b1;
			end
			OP_TRAVERSE: begin
				status_c = ST_EMPTY;
				emit_c   = (len_q == '0);
			end
			default: emit_c = 1'b0;
		endcase
	end

	assign del_idx = pos_c[IW-1:0];

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_mode[i] = CM_HOLD;
			if (state_q == S_TRAV) begin
				if (CMPW'(i) + CMPW'(1) < len_c)
					cell_mode[i] = CM_RIGHT;
				else if (CMPW'(i) + CMPW'(1) == len_c)
					cell_mode[i] = CM_FRONT;
			end else if (accept && do_ins) begin
				if (CMPW'(i) == pos_c)
					cell_mode[i] = CM_LOAD;
				else if (CMPW'(i) > pos_c)
					cell_mode[i] = CM_LEFT;
			end else if (accept && do_del) begin
				if (CMPW'(i) >= pos_c && i < CAPACITY - 1)
					cell_mode[i] = CM_RIGHT;
			end
		end
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		ple_cell u_cell (
			.clk       (clk),
			.mode      (cell_mode[g]),
			.left_val  ((g == 0) ? req.value : cell_val[(g == 0) ? 0 : g - 1]),
			.right_val ((g == CAPACITY - 1) ? cell_val[g]
			                                : cell_val[(g == CAPACITY - 1) ? g : g + 1]),
			.front_val (cell_val[0]),
			.new_val   (req.value),
			.val       (cell_val[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_valid_q <= emit_c;
						if (do_ins)
							len_q <= len_q + LW'(1);
						if (do_del)
							len_q <= len_q - LW'(1);
						if (req.op == OP_TRAVERSE && len_q != '0) begin
							state_q <= S_TRAV;
							cnt_q   <= '0;
						end
					end
				end
				S_TRAV: begin
					rsp_valid_q <= 1'b1;
					cnt_q       <= cnt_q + LW'(1);
					if (cnt_q + LW'(1) == len_q)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_TRAV) begin
			rsp_q.status <= ST_OK;
			rsp_q.data   <= cell_val[0];
			rsp_q.last   <= (cnt_q + LW'(1) == len_q);
		end else if (accept) begin
			rsp_q.status <= status_c;
			rsp_q.data   <= do_del ? cell_val[del_idx] : '0;
			rsp_q.last   <= 1'b1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[hw/rtl/ple_cell.sv]
// One storage cell of the list chain.
module ple_cell (
	input  logic                clk,
	input  ple_pkg::cell_mode_t mode,
	input  logic signed [31:0]  left_val,
	input  logic signed [31:0]  right_val,
	input  logic signed [31:0]  front_val,
	input  logic signed [31:0]  new_val,
	output logic signed [31:0]  val
);
	import ple_pkg::*;

	logic signed [31:0] val_q;

	always_ff @(posedge clk) begin
		case (mode)
			CM_LEFT:  val_q <= left_val;
			CM_RIGHT: val_q <= right_val;
			CM_LOAD:  val_q <= new_val;
			CM_FRONT: val_q <= front_val;
			default:  val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

[bench/tb_positional_list_engine_core.sv]
// Self-checking testbench for the positional list engine: directed corner cases, then random traffic.
`timescale 1ns / 100ps

module tb_positional_list_engine_core;
	import ple_pkg::*;

	localparam int          CAPACITY       = 16;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          DRAIN_CYCLES   = 24;
	localparam logic [2:0]  OP_UNUSED      = 3'd7;

	logic clk;
	logic arst_n;
	logic start;
	req_t req;
	logic busy;
	logic rsp_valid;
	rsp_t rsp;

	logic signed [31:0] shadow_list [CAPACITY];
	int                 shadow_len;
	rsp_t               expected_rsp [$];

	bit back_to_back;
	int fail_count = 0;
	int n_requests;
	int n_results = 0;
	int full_hits;
	int empty_hits;
	int idle_cycles = 0;

	positional_list_engine_core #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.busy     (busy),
		.rsp_valid(rsp_valid),
		.rsp      (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [2:0] shadow_insert(input int pos, input logic signed [31:0] v);
		if (shadow_len >= CAPACITY)
			return ST_OVERFLOW;
		if (pos > shadow_len)
			return ST_BEYOND;
		for (int i = shadow_len; i > pos; i--)
			shadow_list[i] = shadow_list[i - 1];
		shadow_list[pos] = v;
		shadow_len++;
		return ST_OK;
	endfunction

	function automatic logic signed [31:0] shadow_remove(input int pos);
		logic signed [31:0] v;
		v = shadow_list[pos];
		for (int i = pos; i + 1 < shadow_len; i++)
			shadow_list[i] = shadow_list[i + 1];
		shadow_len--;
		return v;
	endfunction

	// Update the shadow list for one accepted request and queue the responses it owes.
	task automatic shadow_apply(input req_t r);
		logic [2:0]         st;
		logic signed [31:0] dat;
		int                 pos;
		st = ST_OK;
		dat = '0;
		pos = $signed(r.position);
		if (shadow_len == CAPACITY)
			full_hits++;
		if (shadow_len == 0)
			empty_hits++;
		case (r.op)
			OP_INS_FRONT: st = shadow_insert(0, r.value);
			OP_INS_END:   st = shadow_insert(shadow_len, r.value);
			OP_INS_AT: begin
				if (pos < 0)
					st = ST_BADPOS;
				else
					st = shadow_insert(pos, r.value);
			end
			OP_DEL_FRONT: begin
				if (shadow_len == 0)
					st = ST_UNDERFLOW;
				else
					dat = shadow_remove(0);
			end
			OP_DEL_END: begin
				if (shadow_len == 0)
					st = ST_UNDERFLOW;
				else
					dat = shadow_remove(shadow_len - 1);
			end
			OP_DEL_AT: begin
				if (pos < 0)
					st = ST_BADPOS;
				else if (pos == 0 && shadow_len == 0)
					st = ST_UNDERFLOW;
				else if (pos >= shadow_len)
					st = ST_BEYOND;
				else
					dat = shadow_remove(pos);
			end
			OP_TRAVERSE: begin
				if (shadow_len == 0)
					expected_rsp.push_back('{status: ST_EMPTY, data: '0, last: 1'b1});
				for (int i = 0; i < shadow_len; i++)
					expected_rsp.push_back('{status: ST_OK, data: shadow_list[i],
						last: (i == shadow_len - 1)});
				return;
			end
			default: return;
		endcase
		expected_rsp.push_back('{status: st, data: dat, last: 1'b1});
	endtask

	// Called right after a rising edge; returns at the edge where the request is taken.
	task automatic issue(input logic [2:0] op, input logic signed [7:0] pos,
		input logic [31:0] val);
		int gap;
		req_t r;
		gap = back_to_back ? 0 : $urandom_range(0, 16);
		r.op = op;
		r.position = pos;
		r.value = val;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy);
		n_requests++;
		shadow_apply(r);
	endtask

	task automatic test_empty_list();
		issue(OP_TRAVERSE, 0, 0);
		issue(OP_DEL_FRONT, 0, 0);
		issue(OP_DEL_END, 0, 0);
		issue(OP_DEL_AT, 0, 0);
		issue(OP_DEL_AT, 127, 0);
		issue(OP_DEL_AT, -128, 0);
		issue(OP_INS_AT, -1, 32'h5a5a_5a5a);
		issue(OP_INS_AT, 1, 32'ha5a5_a5a5);
		issue(OP_UNUSED, -1, 32'hffff_ffff);
	endtask

	task automatic test_full_list();
		issue(OP_INS_FRONT, 0, 32'h7fff_ffff);
		issue(OP_INS_END, 0, 32'h8000_0000);
		issue(OP_INS_AT, 1, 32'h0);
		issue(OP_INS_AT, 3, 32'hffff_ffff);
		issue(OP_INS_AT, 5, 32'h1234_5678);
		while (shadow_len < CAPACITY)
			issue(OP_INS_AT, 8'($urandom_range(0, shadow_len)), $urandom());
		issue(OP_INS_FRONT, 0, $urandom());
		issue(OP_INS_END, 0, $urandom());
		issue(OP_INS_AT, 127, $urandom());
		issue(OP_INS_AT, -128, $urandom());
		issue(OP_TRAVERSE, 0, 0);
		issue(OP_DEL_AT, 127, 0);
		issue(OP_DEL_AT, 8'(CAPACITY - 1), 0);
	endtask

	task automatic test_random_traffic(input int count);
		int                 sent;
		int                 roll;
		bit                 growing;
		logic [2:0]         op;
		logic signed [7:0]  pos;
		logic [31:0]        val;
		sent = 0;
		growing = 1'b0;
		while (sent < count) begin
			if (sent % 25 == 0)
				back_to_back = ($urandom_range(0, 2) == 0);
			if (shadow_len == CAPACITY)
				growing = 1'b0;
			else if (shadow_len == 0 || $urandom_range(0, 29) == 0)
				growing = (shadow_len == 0) ? 1'b1 : ~growing;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				op = OP_UNUSED;
			else if (roll < 13)
				op = OP_TRAVERSE;
			else if ((roll < 63) == growing) begin
				case ($urandom_range(0, 2))
					0:       op = OP_INS_FRONT;
					1:       op = OP_INS_END;
					default: op = OP_INS_AT;
				endcase
			end else begin
				case ($urandom_range(0, 2))
					0:       op = OP_DEL_FRONT;
					1:       op = OP_DEL_END;
					default: op = OP_DEL_AT;
				endcase
			end
			case ($urandom_range(0, 9))
				0:       pos = 8'($urandom());
				1:       pos = 8'(shadow_len + $urandom_range(0, 2));
				default: pos = 8'($urandom_range(0, shadow_len));
			endcase
			case ($urandom_range(0, 19))
				0:       val = 32'h7fff_ffff;
				1:       val = 32'h8000_0000;
				2:       val = 32'h0;
				3:       val = 32'hffff_ffff;
				default: val = $urandom();
			endcase
			issue(op, pos, val);
			if (op != OP_UNUSED)
				sent++;
		end
	endtask

	always @(posedge clk) begin : check_results
		rsp_t want;
		if (arst_n && rsp_valid) begin
			if (expected_rsp.size() == 0) begin
				$error("unexpected response: status %0d data %0d last %0d",
					rsp.status, rsp.data, rsp.last);
				fail_count++;
			end else begin
				want = expected_rsp.pop_front();
				n_results++;
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					fail_count++;
				end
				if (rsp.data !== want.data) begin
					$error("data: expected %0d, actual %0d", want.data, rsp.data);
					fail_count++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, rsp.last);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_valid) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		shadow_len = 0;
		back_to_back = 1'b0;
		n_requests = 0;
		full_hits = 0;
		empty_hits = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_full_list();
		test_random_traffic(185);

		start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d responses checked", n_requests, n_results);
		$display("list was full at %0d requests and empty at %0d", full_hits, empty_hits);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine_core.sv
bench/tb_positional_list_engine_core.sv
